// ===== rtl/zcw_pkg.sv =====
// Shared types and constants for the ZNCC window energy block.
// No dependencies; the files that use it refer to it by scoped names.
package zcw_pkg;

	localparam int WindowRadius = 3;
	localparam int Win = 2 * WindowRadius + 1;
	localparam int StoreRows = 2 * WindowRadius;
	localparam int WinTaps = Win * Win;
	localparam int MinStride = Win;
	localparam int PhW = $clog2(StoreRows);
	localparam int RowsW = $clog2(WindowRadius + 1);
	localparam int TapW = $clog2(WinTaps);

	// Moment widths: count, first sums, second sums, products, differences.
	localparam int NW = 6;
	localparam int SW = 16;
	localparam int QW = 26;
	localparam int MW = QW + SW;
	localparam int DW = MW + 1;

	localparam logic [11:0] RowStrideReset = 12'd2048;
	localparam logic [15:0] EnergyOne = 16'd32768;
	localparam logic RegRowStride = 1'b0;

	typedef struct packed {
		logic [9:0] intensity_a;
		logic [9:0] intensity_b;
		logic       present_a;
		logic       present_b;
	} pixel_t;

	typedef struct packed {
		logic [15:0] energy;
		logic        centre_valid;
	} result_t;

	typedef struct packed {
		logic       present_b;
		logic       present_a;
		logic [9:0] b;
		logic [9:0] a;
	} px_t;

	typedef px_t [StoreRows-1:0] column_t;

	typedef struct packed {
		logic       use_px;
		logic [9:0] a;
		logic [9:0] b;
	} tap_t;

	typedef struct packed {
		logic clear;
		logic acc;
		logic start;
	} mom_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SUM,
		ST_MOMENTS,
		ST_ROOT,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/zcw_line_store.sv =====
// Line store: one word per column holding all stored rows of that column.
// Synchronous write, registered read; uses zcw_pkg for the word type.
module zcw_line_store #(
	parameter int Depth = 2048,
	parameter int AW = 11
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  zcw_pkg::column_t       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output zcw_pkg::column_t       rdata
);

	zcw_pkg::column_t mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/zcw_moments.sv =====
// Window moment accumulator and covariance terms C, F, G and product F*G.
// One shared multiplier works the C, F and G terms in sequence; uses zcw_pkg.
module zcw_moments (
	input  logic                               clk,
	input  logic                               arst_n,
	input  zcw_pkg::mom_ctl_t                  ctl,
	input  zcw_pkg::tap_t                      tap,
	output logic                               done,
	output logic signed [zcw_pkg::DW-1:0]      c,
	output logic [63:0]                        fg,
	output logic                               degenerate
);

	logic [zcw_pkg::NW-1:0] n_q;
	logic [zcw_pkg::SW-1:0] sa_q, sb_q;
	logic [zcw_pkg::QW-1:0] saa_q, sbb_q, sab_q;
	logic [2:0] k_q;
	logic busy_q, done_q;
	logic [zcw_pkg::MW-1:0] prod_q, hold_q;
	logic signed [zcw_pkg::DW-1:0] c_q, f_q, g_q, dif;
	logic [63:0] fg_q;
	logic degen_q;
	logic [zcw_pkg::QW-1:0] mx;
	logic [zcw_pkg::SW-1:0] my;
	logic [19:0] aa, bb, ab;

	assign aa = 20'(tap.a) * 20'(tap.a);
	assign bb = 20'(tap.b) * 20'(tap.b);
	assign ab = 20'(tap.a) * 20'(tap.b);
	assign dif = $signed({1'b0, hold_q}) - $signed({1'b0, prod_q});

	always_comb begin
		unique case (k_q)
			3'd0: begin mx = sab_q; my = zcw_pkg::SW'(n_q); end
			3'd1: begin mx = zcw_pkg::QW'(sa_q); my = sb_q; end
			3'd2: begin mx = saa_q; my = zcw_pkg::SW'(n_q); end
			3'd3: begin mx = zcw_pkg::QW'(sa_q); my = sa_q; end
			3'd4: begin mx = sbb_q; my = zcw_pkg::SW'(n_q); end
			3'd5: begin mx = zcw_pkg::QW'(sb_q); my = sb_q; end
			default: begin mx = '0; my = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 3'd1;
				if (k_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			n_q <= '0;
			sa_q <= '0;
			sb_q <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
		end else if (ctl.acc && tap.use_px) begin
			n_q <= n_q + 1'b1;
			sa_q <= sa_q + zcw_pkg::SW'(tap.a);
			sb_q <= sb_q + zcw_pkg::SW'(tap.b);
			saa_q <= saa_q + zcw_pkg::QW'(aa);
			sbb_q <= sbb_q + zcw_pkg::QW'(bb);
			sab_q <= sab_q + zcw_pkg::QW'(ab);
		end
		if (busy_q && !ctl.start) begin
			prod_q <= zcw_pkg::MW'(mx) * zcw_pkg::MW'(my);
			case (k_q)
				3'd1, 3'd3, 3'd5: hold_q <= prod_q;
				3'd2: c_q <= dif;
				3'd4: f_q <= dif;
				3'd6: g_q <= dif;
				3'd7: begin
					fg_q <= 64'(f_q[31:0]) * 64'(g_q[31:0]);
					degen_q <= f_q[zcw_pkg::DW-1] || (f_q == '0)
						|| g_q[zcw_pkg::DW-1] || (g_q == '0);
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign c = c_q;
	assign fg = fg_q;
	assign degenerate = degen_q;

endmodule

// ===== rtl/zcw_isqrt.sv =====
// Integer square root of a 64-bit value, one result bit per step.
// Thirty-two steps, one per cycle; no package dependency.
module zcw_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] v,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q, res_q, bit_q, t;
	logic [4:0] cnt_q;
	logic busy_q, done_q;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ===== rtl/zcw_frac_div.sv =====
// Restoring divider for the rounded energy fraction (D - C + D/32768) / 2D.
// Sixteen quotient bits, one per cycle; uses zcw_pkg constants.
module zcw_frac_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   root,
	input  logic signed [zcw_pkg::DW-1:0] c,
	output logic                          done,
	output logic [15:0]                   quot
);

	logic signed [zcw_pkg::DW-1:0] dpos, cl, diff;
	logic [49:0] rem_q, num;
	logic [47:0] dsh_q;
	logic [15:0] q_q;
	logic [3:0] cnt_q;
	logic busy_q, done_q, ge;

	assign dpos = $signed({{(zcw_pkg::DW-32){1'b0}}, root});

	// Correlation is limited to the range minus D to plus D.
	always_comb begin
		if (c > dpos) begin
			cl = dpos;
		end else if (c < -dpos) begin
			cl = -dpos;
		end else begin
			cl = c;
		end
	end

	assign diff = dpos - cl;
	assign num = 50'({diff[33:0], 15'b0}) + 50'(root);
	assign ge = rem_q >= 50'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {root, 16'b0};
			q_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - 50'(dsh_q);
			end
			q_q <= {q_q[14:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = (q_q > zcw_pkg::EnergyOne) ? zcw_pkg::EnergyOne : q_q;

endmodule

// ===== rtl/zncc_window_energy.sv =====
// ZNCC window energy top level: control sequencer, 7x7 window and APB register.
// Depends on zcw_pkg, zcw_line_store, zcw_moments, zcw_isqrt and zcw_frac_div.
//
//   Channel   Signals                                   Direction
//   pixel     pixel_valid, pixel_ready, pixel           in  (one pixel pair per item)
//   result    result_valid, result_ready, result        out (energy, centre_valid)
//   config    psel, penable, pwrite, paddr, pwdata,     APB, row_stride at address 0
//             prdata, pready
//
// After reset a clearing pass writes the whole line store to invalid, one column
// word per cycle; no item is taken during it. An item that yields no result
// returns to idle after the window update; one whose centre is absent goes
// straight on to load the output register. For a full result the item is taken,
// the window updated and its taps summed, then the shared multiplier, the square
// root and the divider run in turn before the output register is loaded. The line
// store is read when an item is taken and written back in the next cycle, so one
// item is in work at a time; a finished result waits in the output register while
// the next item is taken.
module zncc_window_energy #(
	parameter int MAX_ROW_STRIDE = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  zcw_pkg::pixel_t     pixel,
	output logic                result_valid,
	input  logic                result_ready,
	output zcw_pkg::result_t    result
);

	localparam int CW = $clog2(MAX_ROW_STRIDE + 1);
	localparam int AW = $clog2(MAX_ROW_STRIDE);
	localparam int Win = zcw_pkg::Win;
	localparam int Rad = zcw_pkg::WindowRadius;
	localparam int PhW = zcw_pkg::PhW;
	localparam int RowsW = zcw_pkg::RowsW;
	localparam int TapW = zcw_pkg::TapW;

	zcw_pkg::state_t state_q, state_d;
	logic [11:0] row_stride_q;
	logic [CW-1:0] stride_eff, col_q, col_eff, col_inc;
	logic [PhW-1:0] phase_q, phase_eff, phase_adv;
	logic [RowsW-1:0] rows_q, rows_eff, rows_adv;
	logic wrap_start, wrap_end;
	zcw_pkg::px_t cur_q;
	zcw_pkg::px_t win_q [Win][Win];
	zcw_pkg::px_t win_d [Win][Win];
	zcw_pkg::tap_t scan_q [zcw_pkg::WinTaps];
	logic [TapW-1:0] sum_cnt_q;
	logic [AW-1:0] clr_addr_q;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	zcw_pkg::column_t mem_wdata, mem_rdata;
	zcw_pkg::mom_ctl_t mom_ctl;
	logic mom_done, mom_degen;
	logic signed [zcw_pkg::DW-1:0] mom_c;
	logic [63:0] mom_fg;
	logic root_start, root_done, div_start, div_done;
	logic [31:0] root_val;
	logic [15:0] div_q, energy_q;
	logic centre_q;
	zcw_pkg::result_t res_q;
	logic res_valid_q, res_load;
	logic produce, centre_ok, cfg_we, accept, sum_last;

	// Configuration register; reads return the stored value, or zero when paddr[2] is set.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == zcw_pkg::RegRowStride);
	assign prdata = (paddr[2] == zcw_pkg::RegRowStride) ? 32'(row_stride_q) : '0;

	always_comb begin
		if (row_stride_q < 12'(zcw_pkg::MinStride)) begin
			stride_eff = CW'(zcw_pkg::MinStride);
		end else if (32'(row_stride_q) > 32'(MAX_ROW_STRIDE)) begin
			stride_eff = CW'(MAX_ROW_STRIDE);
		end else begin
			stride_eff = CW'(row_stride_q);
		end
	end

	// A stride lowered within a row can leave the column at or past its end:
	// the next item then opens a new row.
	assign phase_adv = (phase_q == PhW'(zcw_pkg::StoreRows - 1)) ? '0 : phase_q + 1'b1;
	assign rows_adv = (rows_q == RowsW'(Rad)) ? rows_q : rows_q + 1'b1;
	assign wrap_start = 32'(col_q) >= 32'(stride_eff);
	assign col_eff = wrap_start ? '0 : col_q;
	assign phase_eff = wrap_start ? phase_adv : phase_q;
	assign rows_eff = wrap_start ? rows_adv : rows_q;
	assign col_inc = col_q + 1'b1;
	assign wrap_end = 32'(col_inc) >= 32'(stride_eff);

	// Window shifts left; the new right column comes from the store in ring order,
	// with the incoming pixel at the bottom.
	always_comb begin
		int s;
		for (int r = 0; r < Win; r++) begin
			for (int j = 0; j < Win - 1; j++) begin
				win_d[r][j] = win_q[r][j + 1];
			end
			win_d[r][Win - 1] = win_q[r][Win - 1];
		end
		for (int r = 0; r < zcw_pkg::StoreRows; r++) begin
			s = int'(phase_q) + r;
			if (s >= zcw_pkg::StoreRows) begin
				s = s - zcw_pkg::StoreRows;
			end
			win_d[r][Win - 1] = mem_rdata[PhW'(s)];
		end
		win_d[Win - 1][Win - 1] = cur_q;
	end

	always_comb begin
		mem_wdata = mem_rdata;
		mem_wdata[phase_q] = cur_q;
		if (state_q == zcw_pkg::ST_CLEAR) begin
			mem_wdata = '0;
		end
	end

	assign produce = (rows_q == RowsW'(Rad)) && (32'(col_q) >= 32'(Rad));
	assign centre_ok = win_d[Rad][Rad].present_a && win_d[Rad][Rad].present_b;
	assign accept = pixel_valid && pixel_ready;
	assign sum_last = sum_cnt_q == TapW'(zcw_pkg::WinTaps - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			zcw_pkg::ST_CLEAR:
				if (clr_addr_q == AW'(MAX_ROW_STRIDE - 1)) state_d = zcw_pkg::ST_IDLE;
			zcw_pkg::ST_IDLE:
				if (pixel_valid) state_d = zcw_pkg::ST_UPDATE;
			zcw_pkg::ST_UPDATE: begin
				if (!produce) begin
					state_d = zcw_pkg::ST_IDLE;
				end else if (!centre_ok) begin
					state_d = zcw_pkg::ST_EMIT;
				end else begin
					state_d = zcw_pkg::ST_SUM;
				end
			end
			zcw_pkg::ST_SUM:
				if (sum_last) state_d = zcw_pkg::ST_MOMENTS;
			zcw_pkg::ST_MOMENTS:
				if (mom_done) state_d = zcw_pkg::ST_ROOT;
			zcw_pkg::ST_ROOT:
				if (root_done) state_d = zcw_pkg::ST_DIVIDE;
			zcw_pkg::ST_DIVIDE:
				if (div_done) state_d = zcw_pkg::ST_EMIT;
			zcw_pkg::ST_EMIT:
				if (!res_valid_q || result_ready) state_d = zcw_pkg::ST_IDLE;
			default: state_d = zcw_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		pixel_ready = 1'b0;
		mem_we = 1'b0;
		mom_ctl = '0;
		root_start = 1'b0;
		div_start = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			zcw_pkg::ST_CLEAR: mem_we = 1'b1;
			zcw_pkg::ST_IDLE: pixel_ready = 1'b1;
			zcw_pkg::ST_UPDATE: begin
				mem_we = 1'b1;
				mom_ctl.clear = 1'b1;
			end
			zcw_pkg::ST_SUM: begin
				mom_ctl.acc = 1'b1;
				mom_ctl.start = sum_last;
			end
			zcw_pkg::ST_MOMENTS: root_start = mom_done;
			zcw_pkg::ST_ROOT: div_start = root_done;
			zcw_pkg::ST_DIVIDE: ;
			zcw_pkg::ST_EMIT: res_load = !res_valid_q || result_ready;
			default: ;
		endcase
	end

	assign mem_re = accept;
	assign mem_raddr = col_eff[AW-1:0];
	assign mem_waddr = (state_q == zcw_pkg::ST_CLEAR) ? clr_addr_q : col_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zcw_pkg::ST_CLEAR;
			row_stride_q <= zcw_pkg::RowStrideReset;
			col_q <= '0;
			phase_q <= '0;
			rows_q <= '0;
			clr_addr_q <= '0;
			sum_cnt_q <= '0;
			res_valid_q <= 1'b0;
			for (int r = 0; r < Win; r++) begin
				for (int j = 0; j < Win; j++) begin
					win_q[r][j] <= '0;
				end
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				row_stride_q <= pwdata[11:0];
			end
			if (state_q == zcw_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (accept) begin
				col_q <= col_eff;
				phase_q <= phase_eff;
				rows_q <= rows_eff;
			end
			if (state_q == zcw_pkg::ST_UPDATE) begin
				win_q <= win_d;
				sum_cnt_q <= '0;
				if (wrap_end) begin
					col_q <= '0;
					phase_q <= phase_adv;
					rows_q <= rows_adv;
				end else begin
					col_q <= col_inc;
				end
			end
			if (state_q == zcw_pkg::ST_SUM) begin
				sum_cnt_q <= sum_cnt_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers. Window columns left of the row start are masked off.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= '{present_b: pixel.present_b, present_a: pixel.present_a,
				b: pixel.intensity_b, a: pixel.intensity_a};
		end
		if (state_q == zcw_pkg::ST_UPDATE) begin
			for (int r = 0; r < Win; r++) begin
				for (int j = 0; j < Win; j++) begin
					scan_q[r * Win + j] <= '{
						use_px: win_d[r][j].present_a && win_d[r][j].present_b
							&& (32'(col_q) + 32'(j) >= 32'(Win - 1)),
						a: win_d[r][j].a, b: win_d[r][j].b};
				end
			end
			if (produce && !centre_ok) begin
				energy_q <= '0;
				centre_q <= 1'b0;
			end
		end else if (state_q == zcw_pkg::ST_SUM) begin
			for (int k = 0; k < zcw_pkg::WinTaps - 1; k++) begin
				scan_q[k] <= scan_q[k + 1];
			end
		end
		if (state_q == zcw_pkg::ST_DIVIDE && div_done) begin
			energy_q <= (mom_degen || root_val == '0) ? zcw_pkg::EnergyOne : div_q;
			centre_q <= 1'b1;
		end
		if (res_load) begin
			res_q <= '{energy: energy_q, centre_valid: centre_q};
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	zcw_line_store #(
		.Depth(MAX_ROW_STRIDE),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	zcw_moments u_moments (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mom_ctl),
		.tap(scan_q[0]),
		.done(mom_done),
		.c(mom_c),
		.fg(mom_fg),
		.degenerate(mom_degen)
	);

	zcw_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(root_start),
		.v(mom_fg),
		.done(root_done),
		.root(root_val)
	);

	zcw_frac_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.root(root_val),
		.c(mom_c),
		.done(div_done),
		.quot(div_q)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == zcw_pkg::ST_CLEAR |-> !pixel_ready)
		else $error("item taken during clearing pass");

	a_energy_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.energy <= zcw_pkg::EnergyOne)
		else $error("energy above one");

	a_absent_centre_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.centre_valid |-> result.energy == '0)
		else $error("absent centre with nonzero energy");

	a_store_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line store read and written in one cycle");

	a_rows_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rows_q) <= 32'(Rad))
		else $error("row count past window radius");

endmodule
